@@ src/twc_pkg.sv @@
// Package for the timing wheel timer table: field widths, codes, the control
// state type and the control group that goes to the entry cells.
// Used by the interfaces, the entry cell and the top level.
package twc_pkg;

  localparam int DEF_WHEEL_SLOTS = 60;
  localparam int DEF_TIMERS      = 16;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 16;
  localparam int DELAY_W  = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_CANCEL  = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

@@ src/twc_if.sv @@
// Request and response channel interfaces of the timing wheel timer table.
// Depends on twc_pkg for the field widths.
interface twc_req_if import twc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   timer_key;
  logic [DELAY_W-1:0] delay;

  modport source (output valid, output mode, output timer_key, output delay, input ready);
  modport sink (input valid, input mode, input timer_key, input delay, output ready);
endinterface

interface twc_rsp_if import twc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [KEY_W-1:0]    expired_key;
  logic [STATUS_W-1:0] status;
  logic                fired;
  logic                last_result;

  modport source (output valid, output kind, output expired_key, output status,
                  output fired, output last_result, input ready);
  modport sink (input valid, input kind, input expired_key, input status,
                input fired, input last_result, output ready);
endinterface

@@ src/twc_cell.sv @@
// One timer entry cell of the rotating entry ring.
// Depends on twc_pkg for the key width and the cell control group.
module twc_cell import twc_pkg::*; #(
  parameter int SLOT_W = 6,
  parameter int IDX_W  = 4,
  parameter int IDX    = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  load_idx,
  input  logic [KEY_W-1:0]  load_key,
  input  logic [SLOT_W-1:0] load_dly,
  input  logic [SLOT_W-1:0] load_dl,
  input  logic              nxt_valid,
  input  logic [KEY_W-1:0]  nxt_key,
  input  logic [SLOT_W-1:0] nxt_dly,
  input  logic [SLOT_W-1:0] nxt_dl,
  input  logic              nxt_canc,
  output logic              valid,
  output logic [KEY_W-1:0]  key,
  output logic [SLOT_W-1:0] dly,
  output logic [SLOT_W-1:0] dl,
  output logic              canc
);

  logic hit;

  assign hit = ctl.load && (load_idx == IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= nxt_valid;
    end else if (hit) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key  <= nxt_key;
      dly  <= nxt_dly;
      dl   <= nxt_dl;
      canc <= nxt_canc;
    end else if (hit) begin
      key  <= load_key;
      dly  <= load_dly;
      dl   <= load_dl;
      canc <= 1'b0;
    end
  end

endmodule

@@ src/timing_wheel_timer_table_unit.sv @@
// Top level of the timing wheel timer table: request decode, control sequencer,
// entry ring and response register. Depends on twc_pkg, twc_if and twc_cell.
//
// The entries sit in a ring of TIMERS cells that rotates by one cell per cycle
// past a head position, where the sequencer examines and updates one entry at a
// time, so every item makes one full turn of the ring. The ring rotates only
// while the sequencer scans, and a tick holds it while an expiry waits for the
// response register. An add first reduces its delay modulo WHEEL_SLOTS in an
// extra reduce step before the scan.
// Items are taken one at a time; the next item is accepted as soon as the
// sequencer is idle, even while the last response is still waiting.
module timing_wheel_timer_table_unit import twc_pkg::*; #(
  parameter int WHEEL_SLOTS = DEF_WHEEL_SLOTS,
  parameter int TIMERS      = DEF_TIMERS
) (
  input logic     clk,
  input logic     rst,
  twc_req_if.sink req,
  twc_rsp_if.source rsp
);

  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W+1)'(WHEEL_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WHEEL_SLOTS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMERS - 1);
  localparam int RED_SH  = DELAY_W + SLOT_W;
  localparam int RECIP_W = DELAY_W + 2;
  localparam int PROD_W  = DELAY_W + RECIP_W;
  localparam int QUO_W   = PROD_W - RED_SH;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RED_SH) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS));
  localparam logic [DELAY_W-1:0] SLOTS_D = DELAY_W'(WHEEL_SLOTS);

  function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SLOTS_X) begin
      s = s - SLOTS_X;
    end
    return s[SLOT_W-1:0];
  endfunction

  state_t state, state_next;
  mode_t mode_q;
  logic [KEY_W-1:0] key_q;
  logic [DELAY_W-1:0] dly_q;
  logic [QUO_W-1:0] quo;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] ptr;
  logic [IDX_W-1:0] cnt;
  logic found;
  logic free_found;
  logic [IDX_W-1:0] free_idx;
  logic hold_valid;
  logic [KEY_W-1:0] hold_key;
  logic hold_fired;

  logic out_valid;
  logic out_kind;
  logic [KEY_W-1:0] out_key;
  status_t out_status;
  logic out_fired;
  logic out_last;

  logic c_valid [TIMERS];
  logic [KEY_W-1:0] c_key [TIMERS];
  logic [SLOT_W-1:0] c_dly [TIMERS];
  logic [SLOT_W-1:0] c_dl [TIMERS];
  logic c_canc [TIMERS];

  logic h_valid;
  logic [KEY_W-1:0] h_key;
  logic [SLOT_W-1:0] h_dly;
  logic [SLOT_W-1:0] h_dl;
  logic h_canc;

  logic accept;
  logic out_free;
  logic is_tick;
  logic head_due;
  logic head_match;
  logic scan_step;
  logic push_mid;
  logic fin_emit;
  logic [SLOT_W-1:0] ptr_inc;
  logic [PROD_W-1:0] prod;
  logic [DELAY_W-1:0] quo_n;
  logic [DELAY_W-1:0] rem_diff;
  logic [SLOT_W-1:0] new_dl;
  logic [SLOT_W-1:0] ref_dl;
  status_t ack_status;
  cell_ctl_t ctl;

  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign is_tick  = (mode_q == MODE_TICK);
  assign ptr_inc  = (ptr == SLOT_LAST) ? '0 : ptr + 1'b1;
  assign prod     = PROD_W'(req.delay) * PROD_W'(RECIP);
  assign quo_n    = DELAY_W'(quo) * SLOTS_D;
  assign rem_diff = dly_q - quo_n;
  assign new_dl   = add_mod(ptr, rem);
  assign ref_dl   = add_mod(ptr, c_dly[0]);

  assign head_due   = c_valid[0] && (c_dl[0] == ptr);
  assign head_match = c_valid[0] && (c_key[0] == key_q);

  always_comb begin
    if (mode_q == MODE_ADD) begin
      ack_status = (found || free_found) ? ST_OK : ST_FULL;
    end else begin
      ack_status = found ? ST_OK : ST_NOT_FOUND;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (mode_t'(req.mode) == MODE_ADD) ? S_REDUCE : S_SCAN;
        end
      end
      S_REDUCE: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_step && cnt == IDX_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready = 1'b0;
    scan_step = 1'b0;
    push_mid  = 1'b0;
    fin_emit  = 1'b0;
    ctl       = '0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_SCAN: begin
        if (is_tick && head_due && hold_valid) begin
          scan_step = out_free;
          push_mid  = out_free;
        end else begin
          scan_step = 1'b1;
        end
        ctl.shift = scan_step;
      end
      S_FINISH: begin
        fin_emit = out_free && (!is_tick || hold_valid);
        ctl.load = (mode_q == MODE_ADD) && !found && free_found;
      end
      default: begin
      end
    endcase
  end

  // Head entry as it re-enters the ring at the tail.
  always_comb begin
    h_valid = c_valid[0];
    h_key   = c_key[0];
    h_dly   = c_dly[0];
    h_dl    = c_dl[0];
    h_canc  = c_canc[0];
    if (is_tick) begin
      if (head_due) begin
        h_valid = 1'b0;
      end
    end else if (head_match) begin
      case (mode_q)
        MODE_ADD: begin
          h_dly  = rem;
          h_dl   = new_dl;
          h_canc = 1'b0;
        end
        MODE_REFRESH: h_dl = ref_dl;
        MODE_CANCEL:  h_canc = 1'b1;
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    logic nv;
    logic [KEY_W-1:0] nk;
    logic [SLOT_W-1:0] nd;
    logic [SLOT_W-1:0] nl;
    logic nc;
    if (i == TIMERS - 1) begin : g_tail
      assign nv = h_valid;
      assign nk = h_key;
      assign nd = h_dly;
      assign nl = h_dl;
      assign nc = h_canc;
    end else begin : g_mid
      assign nv = c_valid[i+1];
      assign nk = c_key[i+1];
      assign nd = c_dly[i+1];
      assign nl = c_dl[i+1];
      assign nc = c_canc[i+1];
    end
    twc_cell #(
      .SLOT_W (SLOT_W),
      .IDX_W  (IDX_W),
      .IDX    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load_idx  (free_idx),
      .load_key  (key_q),
      .load_dly  (rem),
      .load_dl   (new_dl),
      .nxt_valid (nv),
      .nxt_key   (nk),
      .nxt_dly   (nd),
      .nxt_dl    (nl),
      .nxt_canc  (nc),
      .valid     (c_valid[i]),
      .key       (c_key[i]),
      .dly       (c_dly[i]),
      .dl        (c_dl[i]),
      .canc      (c_canc[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ptr        <= '0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      if (push_mid || fin_emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            hold_valid <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            if (mode_t'(req.mode) == MODE_TICK) begin
              ptr <= ptr_inc;
            end
          end
        end
        S_SCAN: begin
          if (scan_step) begin
            if (is_tick) begin
              if (head_due) begin
                hold_valid <= 1'b1;
              end
            end else begin
              if (head_match) begin
                found <= 1'b1;
              end
              if (!c_valid[0] && !free_found) begin
                free_found <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q  <= mode_t'(req.mode);
          key_q   <= req.timer_key;
          dly_q   <= req.delay;
          quo     <= prod[PROD_W-1:RED_SH];
          rem     <= '0;
          cnt     <= '0;
        end
      end
      S_REDUCE: begin
        rem <= rem_diff[SLOT_W-1:0];
      end
      S_SCAN: begin
        if (scan_step) begin
          cnt <= cnt + 1'b1;
          if (is_tick && head_due) begin
            hold_key   <= c_key[0];
            hold_fired <= !c_canc[0];
          end
          if (!is_tick && !c_valid[0] && !free_found) begin
            free_idx <= cnt;
          end
        end
        if (push_mid) begin
          out_kind   <= KIND_EXPIRY;
          out_key    <= hold_key;
          out_status <= ST_OK;
          out_fired  <= hold_fired;
          out_last   <= 1'b0;
        end
      end
      S_FINISH: begin
        if (fin_emit) begin
          out_last <= 1'b1;
          if (is_tick) begin
            out_kind   <= KIND_EXPIRY;
            out_key    <= hold_key;
            out_status <= ST_OK;
            out_fired  <= hold_fired;
          end else begin
            out_kind   <= KIND_ACK;
            out_key    <= key_q;
            out_status <= ack_status;
            out_fired  <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.expired_key = out_key;
  assign rsp.status      = out_status;
  assign rsp.fired       = out_fired;
  assign rsp.last_result = out_last;

endmodule
